// File: rtl/core/rrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared constants and control types of the run-length row decoder.
// ----------------------------------------------------------------------------
package rrd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned NUM_W   = 2;

	localparam logic [BYTE_W-1:0] COUNT_MASK   = 8'h7F;
	localparam logic [BYTE_W-1:0] LITERAL_FLAG = 8'h80;

	localparam logic [NUM_W-1:0] NUM_NONE = 2'd0;
	localparam logic [NUM_W-1:0] NUM_ONE  = 2'd1;
	localparam logic [NUM_W-1:0] NUM_TWO  = 2'd2;

	typedef struct packed {
		logic hdr_load;
		logic end_emit;
		logic lit_emit;
		logic run_load;
		logic run_emit;
	} rrd_cmd_t;

	typedef struct packed {
		logic hdr_zero;
		logic hdr_literal;
		logic rem_one;
		logic rem_le_two;
		logic out_full;
	} rrd_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/rrd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_datapath
// Count register, run value register and the result output register.
// ----------------------------------------------------------------------------
module rrd_datapath (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [rrd_pkg::BYTE_W-1:0] code_byte,
	input  wire logic                     out_ready,
	input  wire rrd_pkg::rrd_cmd_t        cmd,
	output rrd_pkg::rrd_sts_t             sts,
	output logic                          out_valid,
	output logic [rrd_pkg::BYTE_W-1:0]    pixel_first,
	output logic [rrd_pkg::BYTE_W-1:0]    pixel_second,
	output logic [rrd_pkg::NUM_W-1:0]     pixel_count,
	output logic                          row_end,
	output logic                          last
);
	import rrd_pkg::*;

	logic [COUNT_W-1:0] remaining_q;
	logic [BYTE_W-1:0]  run_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  first_q;
	logic [BYTE_W-1:0]  second_q;
	logic [NUM_W-1:0]   count_q;
	logic               row_end_q;
	logic               last_q;
	logic               any_emit;
	logic [BYTE_W-1:0]  hdr_count;

	assign hdr_count = code_byte & COUNT_MASK;
	assign any_emit  = cmd.end_emit | cmd.lit_emit | cmd.run_emit;

	assign sts.hdr_zero    = (hdr_count == '0);
	assign sts.hdr_literal = ((code_byte & LITERAL_FLAG) != '0);
	assign sts.rem_one     = (remaining_q == COUNT_W'(1));
	assign sts.rem_le_two  = (remaining_q <= COUNT_W'(2));
	assign sts.out_full    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (any_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hdr_load) begin
			remaining_q <= hdr_count[COUNT_W-1:0];
		end else if (cmd.lit_emit) begin
			remaining_q <= remaining_q - COUNT_W'(1);
		end else if (cmd.run_emit) begin
			if (sts.rem_le_two) begin
				remaining_q <= '0;
			end else begin
				remaining_q <= remaining_q - COUNT_W'(2);
			end
		end
		if (cmd.run_load) begin
			run_q <= code_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.end_emit) begin
			first_q   <= '0;
			second_q  <= '0;
			count_q   <= NUM_NONE;
			row_end_q <= 1'b1;
			last_q    <= 1'b1;
		end else if (cmd.lit_emit) begin
			first_q   <= code_byte;
			second_q  <= '0;
			count_q   <= NUM_ONE;
			row_end_q <= 1'b0;
			last_q    <= 1'b1;
		end else if (cmd.run_emit) begin
			first_q   <= run_q;
			second_q  <= sts.rem_one ? '0 : run_q;
			count_q   <= sts.rem_one ? NUM_ONE : NUM_TWO;
			row_end_q <= 1'b0;
			last_q    <= sts.rem_le_two;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_first  = first_q;
	assign pixel_second = second_q;
	assign pixel_count  = count_q;
	assign row_end      = row_end_q;
	assign last         = last_q;

endmodule
`default_nettype wire

// File: rtl/core/rrd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_ctrl
// Decoder state machine: header, literal copy, run value and run expansion.
// ----------------------------------------------------------------------------
module rrd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_ready,
	input  wire rrd_pkg::rrd_sts_t sts,
	output logic                   in_ready,
	output rrd_pkg::rrd_cmd_t      cmd
);
	import rrd_pkg::*;

	localparam logic [1:0] ST_HEADER = 2'd0;
	localparam logic [1:0] ST_COPY   = 2'd1;
	localparam logic [1:0] ST_RUNVAL = 2'd2;
	localparam logic [1:0] ST_EXPAND = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       slot_free;
	logic       acc;

	assign slot_free = !sts.out_full || out_ready;
	assign in_ready  = slot_free && (state_q != ST_EXPAND);
	assign acc       = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_HEADER: begin
				if (acc) begin
					if (sts.hdr_zero) begin
						cmd.end_emit = 1'b1;
					end else begin
						cmd.hdr_load = 1'b1;
						state_d      = sts.hdr_literal ? ST_COPY : ST_RUNVAL;
					end
				end
			end
			ST_COPY: begin
				if (acc) begin
					cmd.lit_emit = 1'b1;
					if (sts.rem_one) begin
						state_d = ST_HEADER;
					end
				end
			end
			ST_RUNVAL: begin
				if (acc) begin
					cmd.run_load = 1'b1;
					state_d      = ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				if (slot_free) begin
					cmd.run_emit = 1'b1;
					if (sts.rem_le_two) begin
						state_d = ST_HEADER;
					end
				end
			end
			default: state_d = ST_HEADER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.hdr_load, cmd.end_emit, cmd.lit_emit, cmd.run_load, cmd.run_emit}))
		else $error("rrd_ctrl: more than one command at once");

	a_no_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.end_emit || cmd.lit_emit || cmd.run_emit) |-> slot_free)
		else $error("rrd_ctrl: result emitted into an occupied output register");

	a_runval_expand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUNVAL && acc) |=> (state_q == ST_EXPAND))
		else $error("rrd_ctrl: run value accepted without expansion");

	a_expand_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXPAND) |-> !in_ready)
		else $error("rrd_ctrl: input taken during run expansion");
`endif

endmodule
`default_nettype wire

// File: rtl/core/rle_row_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rle_row_decoder
// Byte run-length decoder for one scanline channel.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, code_byte) takes one compressed byte per
// request. Output channel (out_valid/out_ready) carries one result per
// request: up to two pixel bytes, their count, a row end flag and a last flag
// marking the final result caused by an input byte.
// A literal or row end result is loaded into the output register as its
// byte is accepted. A run value byte is taken, then the run drains at one
// result (two pixels, one for the last of an odd count) per cycle while the
// output register can take it, ceil(count/2) results, with in_ready low;
// the next byte can be taken once the final result is registered and the
// output register has room. A header that loads a count gives no result.
// The rate is set by the single output register: a new result is loaded only
// when it is empty or being taken in the same cycle.
// Reset clears the state machine to the header state and empties the output
// register. When the receiver stalls, the result holds and in_ready drops
// until the output register can take the next result.
// ----------------------------------------------------------------------------
module rle_row_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [rrd_pkg::BYTE_W-1:0] code_byte,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [rrd_pkg::BYTE_W-1:0]      pixel_first,
	output logic [rrd_pkg::BYTE_W-1:0]      pixel_second,
	output logic [rrd_pkg::NUM_W-1:0]       pixel_count,
	output logic                            row_end,
	output logic                            last
);
	import rrd_pkg::*;

	rrd_cmd_t cmd;
	rrd_sts_t sts;

	rrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	rrd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.code_byte    (code_byte),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.pixel_count  (pixel_count),
		.row_end      (row_end),
		.last         (last)
	);

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rle_row_decoder. A queue of compressed bytes
// (directed headers, literals, runs and row ends, then random rows) feeds a
// valid/ready driver. Each accepted byte is decoded by a bench-side row
// decoder into expected pixel results. A monitor compares each accepted
// result field by field, with random gaps on both sides and one long
// receiver hold that backs the decoder up into its input.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES = 200;

	typedef enum logic [1:0] {
		DEC_HEADER,
		DEC_COPY,
		DEC_RUN
	} dec_mode_t;

	typedef struct packed {
		logic [rrd_pkg::BYTE_W-1:0]  p0;
		logic [rrd_pkg::BYTE_W-1:0]  p1;
		logic [rrd_pkg::NUM_W-1:0]   num;
		logic                        eor;
		logic                        lst;
	} pix_res_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [rrd_pkg::BYTE_W-1:0] code_byte = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [rrd_pkg::BYTE_W-1:0] pixel_first;
	logic [rrd_pkg::BYTE_W-1:0] pixel_second;
	logic [rrd_pkg::NUM_W-1:0]  pixel_count;
	logic                       row_end;
	logic                       last;

	logic [rrd_pkg::BYTE_W-1:0] code_q[$];
	pix_res_t                   pix_q[$];

	dec_mode_t                  dec_mode = DEC_HEADER;
	logic [rrd_pkg::COUNT_W-1:0] dec_left = '0;

	int unsigned in_cnt = 0;
	int unsigned out_cnt = 0;
	int unsigned bad_cnt = 0;
	int unsigned cycles = 0;
	logic        rx_hold = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned hold_left = 0;

	rle_row_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_byte    (code_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.pixel_count  (pixel_count),
		.row_end      (row_end),
		.last         (last)
	);

	always #4 clk = ~clk;

	function automatic void decode_code_byte(input logic [rrd_pkg::BYTE_W-1:0] b);
		pix_res_t r;
		logic [rrd_pkg::BYTE_W-1:0] masked;
		logic [rrd_pkg::COUNT_W-1:0] left;
		left = dec_left;
		if (dec_mode != DEC_HEADER && left == 0)
			dec_mode = DEC_HEADER;
		case (dec_mode)
			DEC_COPY: begin
				r = '{p0: b, p1: '0, num: rrd_pkg::NUM_ONE, eor: 1'b0, lst: 1'b1};
				pix_q.push_back(r);
				left = left - 1'b1;
				dec_mode = (left == 0) ? DEC_HEADER : DEC_COPY;
				dec_left = left;
			end
			DEC_RUN: begin
				while (left > 0) begin
					if (left >= 2) begin
						left = left - 2'd2;
						r = '{p0: b, p1: b, num: rrd_pkg::NUM_TWO, eor: 1'b0,
							lst: (left == 0)};
					end else begin
						left = left - 1'b1;
						r = '{p0: b, p1: '0, num: rrd_pkg::NUM_ONE, eor: 1'b0,
							lst: 1'b1};
					end
					pix_q.push_back(r);
				end
				dec_mode = DEC_HEADER;
				dec_left = '0;
			end
			default: begin
				masked = b & rrd_pkg::COUNT_MASK;
				if (masked == 0) begin
					r = '{p0: '0, p1: '0, num: rrd_pkg::NUM_NONE, eor: 1'b1, lst: 1'b1};
					pix_q.push_back(r);
					dec_mode = DEC_HEADER;
					dec_left = '0;
				end else begin
					dec_mode = ((b & rrd_pkg::LITERAL_FLAG) != 0) ? DEC_COPY : DEC_RUN;
					dec_left = masked[rrd_pkg::COUNT_W-1:0];
				end
			end
		endcase
	endfunction

	// driver: hold the request until accepted, then offer the next byte
	always @(posedge clk or negedge arst_n) begin : drv
		logic tx_steady;
		if (!arst_n) begin
			in_valid <= 1'b0;
			code_byte <= '0;
		end else begin
			if (in_valid && in_ready) begin
				decode_code_byte(code_byte);
				in_cnt++;
			end
			if (!in_valid || in_ready) begin
				tx_steady = (in_cnt >= 50 && in_cnt < 80);
				if (code_q.size() != 0 && (tx_steady || $urandom_range(99) >= 21)) begin
					in_valid <= 1'b1;
					code_byte <= code_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted result against the oldest expected one
	always @(posedge clk or negedge arst_n) begin : mon
		pix_res_t want;
		logic rx_steady;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pix_q.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("tb_top: unexpected result %h/%h/%0d/%b/%b",
							pixel_first, pixel_second, pixel_count, row_end, last);
				end else begin
					want = pix_q.pop_front();
					if (pixel_first !== want.p0 || pixel_second !== want.p1 ||
						pixel_count !== want.num || row_end !== want.eor ||
						last !== want.lst) begin
						bad_cnt++;
						if (bad_cnt <= 10)
							$display({"tb_top: result %0d want %h/%h/%0d/%b/%b",
								" got %h/%h/%0d/%b/%b"}, out_cnt,
								want.p0, want.p1, want.num, want.eor, want.lst,
								pixel_first, pixel_second, pixel_count, row_end, last);
					end
				end
				out_cnt++;
			end
			rx_steady = (out_cnt >= 150 && out_cnt < 260);
			out_ready <= !rx_hold && (rx_steady || $urandom_range(99) >= 21);
		end
	end

	// long receiver hold, once, so the decoder backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (rx_hold) begin
			if (hold_left == 0)
				rx_hold <= 1'b0;
			else
				hold_left <= hold_left - 1;
		end else if (!hold_done && out_cnt >= 120) begin
			rx_hold <= 1'b1;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin : stim
		int unsigned n;
		int unsigned pick;
		int unsigned len;
		logic [rrd_pkg::BYTE_W-1:0] hdr;

		// row ends, literals with extreme data, odd/even/max runs
		code_q = '{8'h00, 8'h80, 8'h81, 8'hFF, 8'h83, 8'h00, 8'h7F, 8'h80,
			8'h01, 8'hAA, 8'h02, 8'h55, 8'h7F, 8'hFF, 8'h03, 8'h00, 8'h00};

		n = 0;
		while (n < 93) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				code_q.push_back($urandom_range(1) ? 8'h80 : 8'h00);
				n++;
			end else if (pick < 14) begin
				code_q.push_back(8'($urandom_range(255)));
				n++;
			end else if (pick < 55) begin
				len = (pick < 20) ? $urandom_range(1, 12) : $urandom_range(1, 5);
				hdr = rrd_pkg::LITERAL_FLAG | 8'(len);
				code_q.push_back(hdr);
				repeat (len) code_q.push_back(8'($urandom_range(255)));
				n += len + 1;
			end else begin
				len = (pick < 60) ? $urandom_range(64, 127) : $urandom_range(1, 24);
				hdr = 8'(len);
				code_q.push_back(hdr);
				code_q.push_back(8'($urandom_range(255)));
				n += 2;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (code_q.size() != 0 || in_valid || pix_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_cnt == 0 && pix_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
